[hdl/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, codes and constants of the Modbus RTU slave frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mrs_pkg;

  // Input item operations
  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_EOF  = 2'd1,
    OP_PULL = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  // Frame verdict codes
  localparam logic [2:0] ST_READY   = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_BCAST   = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_BYTE    = 1'b1;

  // Function codes
  localparam logic [7:0] FC_READ_COILS = 8'd1;
  localparam logic [7:0] FC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL = 8'd5;
  localparam logic [7:0] FC_WRITE_HOLD = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI = 8'd16;

  // Exception codes
  localparam logic [7:0] EXC_FUNC  = 8'd1;
  localparam logic [7:0] EXC_ADDR  = 8'd2;
  localparam logic [7:0] EXC_VALUE = 8'd3;
  localparam logic [7:0] EXC_FLAG  = 8'h80;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] MAX_READ_REGS = 16'd125;

  localparam int REPLY_DEPTH = 256;
  localparam int REPLY_AW    = 8;

  // Decoded frame action
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAULT,
    ACT_RCOIL,
    ACT_RREG,
    ACT_WCOIL,
    ACT_WHOLD,
    ACT_WMULTI
  } act_t;

  // Reply layout
  typedef enum logic [1:0] {
    MODE_FAULT,
    MODE_ECHO,
    MODE_COILS,
    MODE_REGS
  } mode_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RX_CRC,
    S_FETCH,
    S_DECODE,
    S_M_HI,
    S_M_LO,
    S_M_WR,
    S_BUILD,
    S_BUILD_CRC,
    S_SEAL_LO,
    S_SEAL_HI,
    S_FINISH,
    S_VERDICT,
    S_PULL
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rx_byte;
    logic load_ireg;
    logic eof_start;
    logic fetch_step;
    logic decode;
    logic store_coil;
    logic store_hold;
    logic multi_hi;
    logic multi_lo;
    logic multi_wr;
    logic emit;
    logic seal_lo;
    logic seal_hi;
    logic finish;
    logic verdict;
    logic pull_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic crc_busy;
    logic early_fail;
    logic fetch_done;
    act_t act;
    logic bcast;
    logic build_done;
    logic multi_last;
    logic pull_avail;
    logic out_free;
  } stat_t;

  // One bit step of the reflected CRC-16
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

`default_nettype wire

[hdl/mrs_ram.sv]
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/mrs_datapath.sv]
// ----------------------------------------------------------------------------
// mrs_datapath
// Frame and reply buffers, bit-serial CRC, decode, data stores and result
// register of the Modbus RTU slave.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_datapath #(
  parameter int COILS        = 32,
  parameter int HOLDING_REGS = 32,
  parameter int INPUT_REGS   = 16,
  parameter int FRAME_BYTES  = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  mrs_pkg::cmd_t cmd,
  output mrs_pkg::stat_t stat,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic [7:0]    rx_byte,
  input  logic [3:0]    reg_index,
  input  logic [15:0]   reg_value,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          result_kind,
  output logic [2:0]    frame_status,
  output logic [8:0]    response_length,
  output logic [7:0]    tx_byte,
  output logic          last_byte
);

  import mrs_pkg::*;

  localparam int CW  = (COILS > 1) ? $clog2(COILS) : 1;
  localparam int HW  = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
  localparam int IW  = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
  localparam int FA  = $clog2(FRAME_BYTES);
  localparam int RCW = $clog2(FRAME_BYTES + 1);

  logic [7:0]     slave_address;
  logic [RCW-1:0] rx_count;
  logic           overrun;
  logic [15:0]    crc;
  logic [3:0]     crc_bits;
  logic [7:0]     hdr [7];
  logic [2:0]     fetch_index;
  mode_t          mode;
  logic [7:0]     exc;
  logic           regsel;
  logic [7:0]     loop_index;
  logic [7:0]     hi_byte;
  logic [8:0]     wp;
  logic [8:0]     reply_length;
  logic [8:0]     reply_pointer;
  logic [2:0]     verdict;
  logic [COILS-1:0] coil_bits;
  logic [15:0]    holding_regs [HOLDING_REGS];
  logic [15:0]    input_regs [INPUT_REGS];

  logic           rx_full;
  logic [8:0]     len9;
  logic [FA-1:0]  frame_raddr;
  logic [7:0]     frame_rdata;
  logic [7:0]     reply_rdata;
  logic           reply_we;
  logic [7:0]     reply_wdata;
  logic           crc_load;
  logic [7:0]     crc_byte;

  logic [7:0]     fa;
  logic [7:0]     fc;
  logic [15:0]    start;
  logic [15:0]    word4;
  logic [7:0]     bcnt;
  logic [16:0]    span;
  logic           bcast;
  act_t           dec_act;
  logic [7:0]     dec_exc;
  logic [2:0]     dec_status;
  logic [2:0]     early_status;
  logic           early_fail;
  mode_t          dec_mode;

  logic [13:0]    coil_bytes;
  logic [8:0]     total;
  logic [8:0]     off;
  logic [7:0]     cbyte;
  logic [15:0]    rword;
  logic [7:0]     rbyte;
  logic [7:0]     gen;
  logic [16:0]    midx;

  assign rx_full = (rx_count >= RCW'(FRAME_BYTES));
  assign len9    = 9'(rx_count);

  assign fa    = hdr[0];
  assign fc    = hdr[1];
  assign start = {hdr[2], hdr[3]};
  assign word4 = {hdr[4], hdr[5]};
  assign bcnt  = hdr[6];
  assign span  = 17'(start) + 17'(word4);
  assign bcast = (fa == 8'd0);
  assign midx  = 17'(start) + 17'(loop_index);

  // Frame buffer
  always_comb begin
    if (cmd.multi_hi) begin
      frame_raddr = FA'(9'd7 + {loop_index, 1'b0});
    end else if (cmd.multi_lo) begin
      frame_raddr = FA'(9'd8 + {loop_index, 1'b0});
    end else begin
      frame_raddr = FA'(fetch_index);
    end
  end

  mrs_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (cmd.rx_byte && !rx_full),
    .waddr(rx_count[FA-1:0]),
    .wdata(rx_byte),
    .raddr(frame_raddr),
    .rdata(frame_rdata)
  );

  // Reply buffer
  assign reply_we = cmd.emit || cmd.seal_lo || cmd.seal_hi;

  always_comb begin
    if (cmd.seal_lo) begin
      reply_wdata = crc[7:0];
    end else if (cmd.seal_hi) begin
      reply_wdata = crc[15:8];
    end else begin
      reply_wdata = gen;
    end
  end

  mrs_ram #(
    .WIDTH(8),
    .DEPTH(REPLY_DEPTH)
  ) u_reply_ram (
    .clk  (clk),
    .we   (reply_we),
    .waddr(wp[REPLY_AW-1:0]),
    .wdata(reply_wdata),
    .raddr(reply_pointer[REPLY_AW-1:0]),
    .rdata(reply_rdata)
  );

  // Length, CRC and overrun checks at end of frame
  always_comb begin
    early_fail = overrun || (len9 < 9'd4) || (crc != 16'd0);
    if (overrun) begin
      early_status = ST_OVERRUN;
    end else if (early_fail) begin
      early_status = ST_BAD;
    end else begin
      early_status = ST_READY;
    end
  end

  // Decode address, length and function
  always_comb begin
    logic       mism;
    logic       short_frame;
    logic [2:0] none_status;
    mism        = !bcast && (fa != slave_address);
    short_frame = ((fc inside {FC_READ_COILS, FC_READ_HOLD, FC_READ_INPUT,
                               FC_WRITE_COIL, FC_WRITE_HOLD}) && (len9 < 9'd8)) ||
                  ((fc == FC_WRITE_MULTI) && (len9 < 9'd9));
    dec_act     = ACT_NONE;
    dec_exc     = EXC_FUNC;
    none_status = ST_BCAST;
    if (mism) begin
      none_status = ST_OTHER;
    end else if (short_frame) begin
      none_status = ST_BAD;
    end else begin
      case (fc)
        FC_READ_COILS: begin
          if (!bcast) begin
            if ((word4 == 16'd0) || (span > 17'(COILS))) begin
              dec_act = ACT_FAULT;
              dec_exc = EXC_ADDR;
            end else begin
              dec_act = ACT_RCOIL;
            end
          end
        end
        FC_READ_HOLD, FC_READ_INPUT: begin
          if (!bcast) begin
            if ((word4 == 16'd0) || (word4 > MAX_READ_REGS)) begin
              dec_act = ACT_FAULT;
              dec_exc = EXC_VALUE;
            end else if (span > ((fc == FC_READ_INPUT) ? 17'(INPUT_REGS)
                                                       : 17'(HOLDING_REGS))) begin
              dec_act = ACT_FAULT;
              dec_exc = EXC_ADDR;
            end else begin
              dec_act = ACT_RREG;
            end
          end
        end
        FC_WRITE_COIL: begin
          if (17'(start) >= 17'(COILS)) begin
            dec_act = ACT_FAULT;
            dec_exc = EXC_ADDR;
          end else if ((word4 != 16'd0) && (word4 != COIL_ON)) begin
            dec_act = ACT_FAULT;
            dec_exc = EXC_VALUE;
          end else begin
            dec_act = ACT_WCOIL;
          end
        end
        FC_WRITE_HOLD: begin
          if (17'(start) >= 17'(HOLDING_REGS)) begin
            dec_act = ACT_FAULT;
            dec_exc = EXC_ADDR;
          end else begin
            dec_act = ACT_WHOLD;
          end
        end
        FC_WRITE_MULTI: begin
          if ((word4 == 16'd0) || (17'(bcnt) != {word4, 1'b0}) ||
              (span > 17'(HOLDING_REGS))) begin
            dec_act = ACT_FAULT;
            dec_exc = EXC_ADDR;
          end else if (len9 < (9'd9 + 9'(bcnt))) begin
            dec_act = ACT_FAULT;
            dec_exc = EXC_VALUE;
          end else begin
            dec_act = ACT_WMULTI;
          end
        end
        default: begin
          dec_act = ACT_FAULT;
          dec_exc = EXC_FUNC;
        end
      endcase
      // Broadcast never answers, not even with an exception
      if (bcast && (dec_act == ACT_FAULT)) begin
        dec_act = ACT_NONE;
      end
    end
    if (dec_act == ACT_NONE) begin
      dec_status = none_status;
    end else begin
      dec_status = bcast ? ST_BCAST : ST_READY;
    end
  end

  always_comb begin
    case (dec_act)
      ACT_FAULT: dec_mode = MODE_FAULT;
      ACT_RCOIL: dec_mode = MODE_COILS;
      ACT_RREG:  dec_mode = MODE_REGS;
      default:   dec_mode = MODE_ECHO;
    endcase
  end

  // Reply byte at the write pointer
  assign coil_bytes = 14'((17'(word4) + 17'd7) >> 3);
  assign off        = wp - 9'd3;

  always_comb begin
    case (mode)
      MODE_FAULT: total = 9'd3;
      MODE_ECHO:  total = 9'd6;
      MODE_COILS: total = 9'd3 + 9'(coil_bytes);
      default:    total = 9'd3 + 9'({word4, 1'b0});
    endcase
  end

  always_comb begin
    logic [16:0] bi;
    logic [16:0] ci;
    for (int j = 0; j < 8; j++) begin
      bi       = 17'({off[7:0], 3'b000}) + 17'(j);
      ci       = 17'(start) + bi;
      cbyte[j] = (bi < 17'(word4)) ? coil_bits[ci[CW-1:0]] : 1'b0;
    end
  end

  always_comb begin
    logic [16:0] ri;
    ri    = 17'(start) + 17'(off[7:1]);
    rword = regsel ? input_regs[ri[IW-1:0]] : holding_regs[ri[HW-1:0]];
    rbyte = off[0] ? rword[7:0] : rword[15:8];
  end

  always_comb begin
    case (wp)
      9'd0: gen = fa;
      9'd1: gen = (mode == MODE_FAULT) ? (fc | EXC_FLAG) : fc;
      9'd2: begin
        case (mode)
          MODE_FAULT: gen = exc;
          MODE_ECHO:  gen = hdr[2];
          MODE_COILS: gen = coil_bytes[7:0];
          default:    gen = {word4[6:0], 1'b0};
        endcase
      end
      default: begin
        case (mode)
          MODE_ECHO:  gen = hdr[wp[2:0]];
          MODE_COILS: gen = cbyte;
          MODE_REGS:  gen = rbyte;
          default:    gen = 8'h00;
        endcase
      end
    endcase
  end

  // Status to the controller
  assign stat.crc_busy   = (crc_bits != 4'd0);
  assign stat.early_fail = early_fail;
  assign stat.fetch_done = (fetch_index == 3'd7);
  assign stat.act        = dec_act;
  assign stat.bcast      = bcast;
  assign stat.build_done = (wp >= total);
  assign stat.multi_last = ((16'(loop_index) + 16'd1) == word4);
  assign stat.pull_avail = (reply_pointer < reply_length);
  assign stat.out_free   = !out_valid || !out_stall;

  // Station address register
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  // Bit-serial CRC: fold in one byte, then shift one bit a cycle
  assign crc_load = (cmd.rx_byte && !rx_full) || cmd.emit;
  assign crc_byte = cmd.emit ? gen : rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_INIT;
      crc_bits <= 4'd0;
    end else if (cmd.decode || cmd.verdict) begin
      crc      <= CRC_INIT;
      crc_bits <= 4'd0;
    end else if (crc_load) begin
      crc      <= crc ^ {8'h00, crc_byte};
      crc_bits <= 4'd8;
    end else if (crc_bits != 4'd0) begin
      crc      <= crc_step(crc);
      crc_bits <= crc_bits - 4'd1;
    end
  end

  // Frame and reply bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count      <= '0;
      overrun       <= 1'b0;
      fetch_index   <= 3'd0;
      mode          <= MODE_FAULT;
      loop_index    <= 8'd0;
      wp            <= 9'd0;
      reply_length  <= 9'd0;
      reply_pointer <= 9'd0;
      verdict       <= ST_READY;
    end else begin
      if (cmd.rx_byte) begin
        if (rx_full) begin
          overrun <= 1'b1;
        end else begin
          rx_count <= rx_count + RCW'(1);
        end
      end
      if (cmd.eof_start) begin
        reply_length  <= 9'd0;
        reply_pointer <= 9'd0;
        wp            <= 9'd0;
        fetch_index   <= 3'd0;
        verdict       <= early_status;
      end
      if (cmd.fetch_step) begin
        fetch_index <= fetch_index + 3'd1;
      end
      if (cmd.decode) begin
        verdict    <= dec_status;
        mode       <= dec_mode;
        loop_index <= 8'd0;
      end
      if (cmd.multi_wr) begin
        loop_index <= loop_index + 8'd1;
      end
      if (reply_we) begin
        wp <= wp + 9'd1;
      end
      if (cmd.finish) begin
        reply_length <= wp;
      end
      if (cmd.pull_out) begin
        reply_pointer <= reply_pointer + 9'd1;
      end
      if (cmd.verdict) begin
        rx_count <= '0;
        overrun  <= 1'b0;
      end
    end
  end

  // Header capture and latched decode fields
  always_ff @(posedge clk) begin
    if (cmd.fetch_step && (fetch_index != 3'd0)) begin
      hdr[3'(fetch_index - 3'd1)] <= frame_rdata;
    end
    if (cmd.decode) begin
      exc    <= dec_exc;
      regsel <= (fc == FC_READ_INPUT);
    end
    if (cmd.multi_lo) begin
      hi_byte <= frame_rdata;
    end
  end

  // Coil, holding and input stores
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_bits <= '0;
      for (int i = 0; i < HOLDING_REGS; i++) begin
        holding_regs[i] <= 16'd0;
      end
      for (int i = 0; i < INPUT_REGS; i++) begin
        input_regs[i] <= 16'd0;
      end
    end else begin
      if (cmd.store_coil) begin
        coil_bits[start[CW-1:0]] <= (word4 == COIL_ON);
      end
      if (cmd.store_hold) begin
        holding_regs[start[HW-1:0]] <= word4;
      end
      if (cmd.multi_wr) begin
        holding_regs[midx[HW-1:0]] <= {hi_byte, frame_rdata};
      end
      if (cmd.load_ireg && (32'(reg_index) < 32'(INPUT_REGS))) begin
        input_regs[IW'(reg_index)] <= reg_value;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.verdict || cmd.pull_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.verdict) begin
      result_kind     <= KIND_VERDICT;
      frame_status    <= verdict;
      response_length <= reply_length;
      tx_byte         <= 8'h00;
      last_byte       <= 1'b0;
    end else if (cmd.pull_out) begin
      result_kind     <= KIND_BYTE;
      frame_status    <= ST_READY;
      response_length <= reply_length - reply_pointer - 9'd1;
      tx_byte         <= reply_rdata;
      last_byte       <= ((reply_pointer + 9'd1) == reply_length);
    end
  end

endmodule

`default_nettype wire

[hdl/mrs_ctrl.sv]
// ----------------------------------------------------------------------------
// mrs_ctrl
// Sequencer of the Modbus RTU slave: accepts items, steps the frame check,
// execution, reply build and reply hand-out.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     operation,
  input  mrs_pkg::stat_t stat,
  output logic           in_stall,
  output mrs_pkg::cmd_t  cmd
);

  import mrs_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  op_t    op;

  assign op       = op_t'(operation);
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_RX:   state_next = S_RX_CRC;
            OP_EOF:  state_next = stat.early_fail ? S_VERDICT : S_FETCH;
            OP_PULL: state_next = stat.pull_avail ? S_PULL : S_IDLE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RX_CRC: begin
        if (!stat.crc_busy) state_next = S_IDLE;
      end
      S_FETCH: begin
        if (stat.fetch_done) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.act)
          ACT_NONE:   state_next = S_VERDICT;
          ACT_WCOIL,
          ACT_WHOLD:  state_next = stat.bcast ? S_VERDICT : S_BUILD;
          ACT_WMULTI: state_next = S_M_HI;
          default:    state_next = S_BUILD;
        endcase
      end
      S_M_HI: state_next = S_M_LO;
      S_M_LO: state_next = S_M_WR;
      S_M_WR: begin
        if (stat.multi_last) begin
          state_next = stat.bcast ? S_VERDICT : S_BUILD;
        end else begin
          state_next = S_M_HI;
        end
      end
      S_BUILD: begin
        state_next = stat.build_done ? S_SEAL_LO : S_BUILD_CRC;
      end
      S_BUILD_CRC: begin
        if (!stat.crc_busy) state_next = S_BUILD;
      end
      S_SEAL_LO: state_next = S_SEAL_HI;
      S_SEAL_HI: state_next = S_FINISH;
      S_FINISH:  state_next = S_VERDICT;
      S_VERDICT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_PULL: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_RX:   cmd.rx_byte   = 1'b1;
            OP_EOF:  cmd.eof_start = 1'b1;
            OP_LOAD: cmd.load_ireg = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      S_FETCH:  cmd.fetch_step = 1'b1;
      S_DECODE: begin
        cmd.decode     = 1'b1;
        cmd.store_coil = (stat.act == ACT_WCOIL);
        cmd.store_hold = (stat.act == ACT_WHOLD);
      end
      S_M_HI:    cmd.multi_hi = 1'b1;
      S_M_LO:    cmd.multi_lo = 1'b1;
      S_M_WR:    cmd.multi_wr = 1'b1;
      S_BUILD:   cmd.emit     = !stat.build_done;
      S_SEAL_LO: cmd.seal_lo  = 1'b1;
      S_SEAL_HI: cmd.seal_hi  = 1'b1;
      S_FINISH:  cmd.finish   = 1'b1;
      S_VERDICT: cmd.verdict  = stat.out_free;
      S_PULL:    cmd.pull_out = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/modbus_rtu_slave_frame_engine.sv]
// A received byte is accepted, then shifted through the bit-serial CRC while input stalls.
// End of frame: straight to the verdict when overrun, length or CRC fail; otherwise header
// fetch and decode, high, low and write steps per register of a multiple write, each reply
// byte through the shared bit-serial CRC, CRC seal and verdict, plus any output stall.
// Pull: reply buffer read is registered. Input register load completes on acceptance.
// Synchronous reset clears control state and all stores, station address to 1; not buffers.
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Modbus RTU slave frame engine: frame buffering, CRC check, function
// execution on the coil and register stores, and reply hand-out.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_frame_engine #(
  parameter int COILS        = 32,
  parameter int HOLDING_REGS = 32,
  parameter int INPUT_REGS   = 16,
  parameter int FRAME_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  input  logic [3:0]  reg_index,
  input  logic [15:0] reg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [2:0]  frame_status,
  output logic [8:0]  response_length,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  import mrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .operation(operation),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath
  mrs_datapath #(
    .COILS       (COILS),
    .HOLDING_REGS(HOLDING_REGS),
    .INPUT_REGS  (INPUT_REGS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .rx_byte        (rx_byte),
    .reg_index      (reg_index),
    .reg_value      (reg_value),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .result_kind    (result_kind),
    .frame_status   (frame_status),
    .response_length(response_length),
    .tx_byte        (tx_byte),
    .last_byte      (last_byte)
  );

  // A failed or silent verdict announces no reply
  a_silent_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_VERDICT) && (frame_status != ST_READY))
      |-> (response_length == 9'd0))
    else $error("nonzero reply length on a silent verdict");

  // A reply byte is flagged last exactly when nothing is left
  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_BYTE)) |-> (last_byte == (response_length == 9'd0)))
    else $error("last byte flag disagrees with remaining length");

  // A verdict carries no transmit byte
  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_VERDICT)) |-> ((tx_byte == 8'h00) && !last_byte))
    else $error("verdict carries transmit data");

endmodule

`default_nettype wire
